### rtl/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types, constants and helpers for the ray / triangle intersect block.
// ----------------------------------------------------------------------------
`default_nettype none

package rti_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned ACC_W     = 68;
  localparam int unsigned NORM_BITS = 14;
  localparam int unsigned NORM_W    = 16;
  localparam int unsigned EPS_W     = 31;
  localparam int unsigned TERM_W    = 3;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE, ST_EDGE, ST_MUL, ST_ACC, ST_WB, ST_DIV_GO, ST_DIV_RUN,
    ST_DIV_WB, ST_CHECK, ST_SQRT_GO, ST_SQRT_RUN, ST_OUT
  } state_e;

  // datapath phase commanded in a cycle
  typedef enum logic [3:0] {
    PH_NONE, PH_EDGE, PH_MUL, PH_ACC, PH_WB, PH_DIV_GO, PH_DIV_WB,
    PH_SQRT_GO, PH_OUT
  } phase_e;

  // computation being sequenced
  typedef enum logic [3:0] {
    OP_P, OP_DET, OP_U, OP_Q, OP_V, OP_T, OP_PT, OP_N, OP_SS, OP_NRM
  } op_e;

  typedef struct packed {
    logic               take;
    phase_e             phase;
    op_e                op;
    logic [TERM_W-1:0]  term;
    logic               clr;
    logic               out_hit;
  } cmd_t;

  typedef struct packed {
    logic det_rej;
    logic u_rej;
    logic v_rej;
    logic t_rej;
    logic len_zero;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } stat_t;

  function automatic logic is_cross(op_e op);
    return (op == OP_P) || (op == OP_Q) || (op == OP_N);
  endfunction

  function automatic logic is_dot(op_e op);
    return (op == OP_DET) || (op == OP_U) || (op == OP_V) || (op == OP_T) ||
           (op == OP_SS);
  endfunction

  // next index modulo three
  function automatic logic [1:0] inc3(logic [1:0] k);
    return (k == 2'd2) ? 2'd0 : k + 2'd1;
  endfunction

  // saturate a wide signed value to 32 bits
  function automatic logic signed [COORD_W-1:0] sat32(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed({{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
    lo = $signed({{(ACC_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}});
    if (v > hi) return hi[COORD_W-1:0];
    if (v < lo) return lo[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/rti_ctrl.sv
// ----------------------------------------------------------------------------
// rti_ctrl
// Sequencer: walks the products, divisions and root of one triangle test.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           mode_i,
  output logic                in_stall_o,
  input  wire rti_pkg::stat_t stat_i,
  output rti_pkg::cmd_t       cmd_o
);

  rti_pkg::state_e           state_q, state_d;
  rti_pkg::op_e              op_q, op_d;
  logic [rti_pkg::TERM_W-1:0] term_q, term_d;
  logic                      hit_q, hit_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rti_pkg::ST_IDLE;
      op_q    <= rti_pkg::OP_P;
      term_q  <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      term_q  <= term_d;
      hit_q   <= hit_d;
    end
  end

  assign in_stall_o = (state_q != rti_pkg::ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    term_d  = term_q;
    hit_d   = hit_q;
    cmd_o   = '0;
    cmd_o.phase   = rti_pkg::PH_NONE;
    cmd_o.op      = op_q;
    cmd_o.term    = term_q;
    cmd_o.out_hit = hit_q;
    if (rti_pkg::is_cross(op_q)) cmd_o.clr = ~term_q[0];
    else if (rti_pkg::is_dot(op_q)) cmd_o.clr = (term_q == '0);
    else cmd_o.clr = 1'b1;
    case (state_q)
      rti_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (mode_i) state_d = rti_pkg::ST_EDGE;
        end
      end
      rti_pkg::ST_EDGE: begin
        cmd_o.phase = rti_pkg::PH_EDGE;
        op_d    = rti_pkg::OP_P;
        term_d  = '0;
        state_d = rti_pkg::ST_MUL;
      end
      rti_pkg::ST_MUL: begin
        cmd_o.phase = rti_pkg::PH_MUL;
        state_d = rti_pkg::ST_ACC;
      end
      rti_pkg::ST_ACC: begin
        cmd_o.phase = rti_pkg::PH_ACC;
        if (rti_pkg::is_cross(op_q)) begin
          if (term_q[0]) state_d = rti_pkg::ST_WB;
          else begin
            term_d  = term_q + 1'b1;
            state_d = rti_pkg::ST_MUL;
          end
        end else if (rti_pkg::is_dot(op_q)) begin
          if (term_q == 3'd2) state_d = rti_pkg::ST_WB;
          else begin
            term_d  = term_q + 1'b1;
            state_d = rti_pkg::ST_MUL;
          end
        end else begin
          state_d = rti_pkg::ST_WB;
        end
      end
      rti_pkg::ST_WB: begin
        cmd_o.phase = rti_pkg::PH_WB;
        state_d = rti_pkg::ST_MUL;
        case (op_q)
          rti_pkg::OP_P, rti_pkg::OP_Q, rti_pkg::OP_N: begin
            if (term_q == 3'd5) begin
              term_d = '0;
              if (op_q == rti_pkg::OP_P) op_d = rti_pkg::OP_DET;
              else if (op_q == rti_pkg::OP_Q) op_d = rti_pkg::OP_V;
              else op_d = rti_pkg::OP_SS;
            end else begin
              term_d = term_q + 1'b1;
            end
          end
          rti_pkg::OP_PT: begin
            if (term_q == 3'd2) begin
              term_d = '0;
              op_d   = rti_pkg::OP_N;
            end else begin
              term_d = term_q + 1'b1;
            end
          end
          rti_pkg::OP_DET: state_d = rti_pkg::ST_CHECK;
          rti_pkg::OP_SS:  state_d = rti_pkg::ST_SQRT_GO;
          default:         state_d = rti_pkg::ST_DIV_GO;
        endcase
      end
      rti_pkg::ST_DIV_GO: begin
        cmd_o.phase = rti_pkg::PH_DIV_GO;
        state_d = rti_pkg::ST_DIV_RUN;
      end
      rti_pkg::ST_DIV_RUN: begin
        if (stat_i.div_done) state_d = rti_pkg::ST_DIV_WB;
      end
      rti_pkg::ST_DIV_WB: begin
        cmd_o.phase = rti_pkg::PH_DIV_WB;
        if (op_q == rti_pkg::OP_NRM) begin
          if (term_q == 3'd2) state_d = rti_pkg::ST_OUT;
          else begin
            term_d  = term_q + 1'b1;
            state_d = rti_pkg::ST_DIV_GO;
          end
        end else begin
          state_d = rti_pkg::ST_CHECK;
        end
      end
      rti_pkg::ST_CHECK: begin
        term_d  = '0;
        state_d = rti_pkg::ST_MUL;
        case (op_q)
          rti_pkg::OP_DET: begin
            op_d = rti_pkg::OP_U;
            if (stat_i.det_rej) begin
              hit_d   = 1'b0;
              state_d = rti_pkg::ST_OUT;
            end
          end
          rti_pkg::OP_U: begin
            op_d = rti_pkg::OP_Q;
            if (stat_i.u_rej) begin
              hit_d   = 1'b0;
              state_d = rti_pkg::ST_OUT;
            end
          end
          rti_pkg::OP_V: begin
            op_d = rti_pkg::OP_T;
            if (stat_i.v_rej) begin
              hit_d   = 1'b0;
              state_d = rti_pkg::ST_OUT;
            end
          end
          default: begin
            op_d  = rti_pkg::OP_PT;
            hit_d = ~stat_i.t_rej;
            if (stat_i.t_rej) state_d = rti_pkg::ST_OUT;
          end
        endcase
      end
      rti_pkg::ST_SQRT_GO: begin
        cmd_o.phase = rti_pkg::PH_SQRT_GO;
        state_d = rti_pkg::ST_SQRT_RUN;
      end
      rti_pkg::ST_SQRT_RUN: begin
        if (stat_i.sqrt_done) begin
          term_d = '0;
          op_d   = rti_pkg::OP_NRM;
          state_d = stat_i.len_zero ? rti_pkg::ST_OUT : rti_pkg::ST_DIV_GO;
        end
      end
      rti_pkg::ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.phase = rti_pkg::PH_OUT;
          state_d = rti_pkg::ST_IDLE;
        end
      end
      default: state_d = rti_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/rti_dp.sv
// ----------------------------------------------------------------------------
// rti_dp
// Datapath: shared multiply-accumulate, serial divider, serial square root.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_dp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire rti_pkg::cmd_t           cmd_i,
  output rti_pkg::stat_t               stat_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [30:0]             cfg_wdata_i,
  input  wire logic                    mode_i,
  input  wire logic signed [31:0]      a_x_i, a_y_i, a_z_i,
  input  wire logic signed [31:0]      b_x_i, b_y_i, b_z_i,
  input  wire logic signed [31:0]      c_x_i, c_y_i, c_z_i,
  input  wire logic signed [31:0]      t_limit_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         hit_o,
  output logic signed [31:0]           hit_t_o,
  output logic signed [31:0]           point_x_o, point_y_o, point_z_o,
  output logic signed [15:0]           normal_x_o, normal_y_o, normal_z_o
);

  localparam int unsigned AW    = rti_pkg::ACC_W;
  localparam int unsigned SH_MX = (FRAC_BITS > rti_pkg::NORM_BITS) ? FRAC_BITS
                                                                   : rti_pkg::NORM_BITS;
  localparam int unsigned DW    = 32 + SH_MX;
  localparam int unsigned CW    = $clog2(DW + 1);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  typedef logic signed [31:0] vec_t [3];

  vec_t org_q, dir_q, va_q, vb_q, vc_q;
  vec_t e1_q, e2_q, tv_q, pv_q, qv_q, nv_q, pt_q;
  logic signed [15:0] nn_q [3];
  logic signed [31:0] best_q, det_q, num_q, u_q, v_q, t_q;
  logic [30:0]        eps_q;
  logic signed [63:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic [63:0]        ss_q;

  // serial divider state
  logic [DW-1:0] dn_q, dq_q;
  logic [32:0]   drem_q;
  logic [31:0]   dden_q;
  logic          dneg_q;
  logic [CW-1:0] dcnt_q;

  // serial square root state
  logic [63:0] sx_q, sres_q, sbit_q;

  // operand selection for the multiplier
  logic [1:0] comp, ia, ib;
  logic signed [31:0] opa, opb;
  always_comb begin
    comp = cmd_i.term[2:1];
    if (rti_pkg::is_cross(cmd_i.op)) begin
      ia = cmd_i.term[0] ? rti_pkg::inc3(rti_pkg::inc3(comp)) : rti_pkg::inc3(comp);
      ib = cmd_i.term[0] ? rti_pkg::inc3(comp) : rti_pkg::inc3(rti_pkg::inc3(comp));
    end else begin
      ia = cmd_i.term[1:0];
      ib = cmd_i.term[1:0];
    end
    case (cmd_i.op)
      rti_pkg::OP_P:   begin opa = dir_q[ia]; opb = e2_q[ib]; end
      rti_pkg::OP_Q:   begin opa = tv_q[ia];  opb = e1_q[ib]; end
      rti_pkg::OP_N:   begin opa = e1_q[ia];  opb = e2_q[ib]; end
      rti_pkg::OP_DET: begin opa = e1_q[ia];  opb = pv_q[ib]; end
      rti_pkg::OP_U:   begin opa = tv_q[ia];  opb = pv_q[ib]; end
      rti_pkg::OP_V:   begin opa = dir_q[ia]; opb = qv_q[ib]; end
      rti_pkg::OP_T:   begin opa = e2_q[ia];  opb = qv_q[ib]; end
      rti_pkg::OP_SS:  begin opa = nv_q[ia];  opb = nv_q[ib]; end
      rti_pkg::OP_PT:  begin opa = t_q;       opb = dir_q[ib]; end
      default:         begin opa = '0;        opb = '0;       end
    endcase
  end

  // accumulate term: shifted product, exact for the squared sum
  logic signed [AW-1:0] term_v, acc_d;
  logic signed [31:0]   acc_sat;
  always_comb begin
    if (cmd_i.op == rti_pkg::OP_SS) term_v = AW'(prod_q);
    else term_v = AW'(prod_q >>> FRAC_BITS);
    if (rti_pkg::is_cross(cmd_i.op) && cmd_i.term[0]) term_v = -term_v;
    acc_d   = (cmd_i.clr ? '0 : acc_q) + term_v;
    acc_sat = rti_pkg::sat32(acc_q);
  end

  // divider operands and quotient saturation
  logic signed [31:0] dnum, dden;
  logic [31:0]        dnum_mag, dden_mag;
  logic [DW-1:0]      dstart;
  logic [32:0]        drem_t;
  logic signed [31:0] dres;
  always_comb begin
    dnum = (cmd_i.op == rti_pkg::OP_NRM) ? nv_q[cmd_i.term[1:0]] : num_q;
    dden = (cmd_i.op == rti_pkg::OP_NRM) ? $signed(sres_q[31:0]) : det_q;
    dnum_mag = dnum[31] ? 32'(-dnum) : dnum;
    dden_mag = (dden[31] && cmd_i.op != rti_pkg::OP_NRM) ? 32'(-dden) : dden;
    if (cmd_i.op == rti_pkg::OP_NRM) dstart = DW'(dnum_mag) << rti_pkg::NORM_BITS;
    else dstart = DW'(dnum_mag) << FRAC_BITS;
    drem_t = {drem_q[31:0], dn_q[DW-1]};
    if (dneg_q) dres = (dq_q > DW'(33'h080000000)) ? 32'sh80000000 : -$signed(dq_q[31:0]);
    else dres = (dq_q > DW'(32'h7fffffff)) ? 32'sh7fffffff : $signed(dq_q[31:0]);
  end

  // square root step
  logic [63:0] s_try;
  assign s_try = sres_q + sbit_q;

  // status toward the controller
  logic [31:0] det_mag;
  assign det_mag = det_q[31] ? 32'(-det_q) : det_q;
  always_comb begin
    stat_o.det_rej   = (det_q == '0) || (det_mag < {1'b0, eps_q});
    stat_o.u_rej     = u_q[31] || (u_q > ONE);
    stat_o.v_rej     = v_q[31] || ((33'(u_q) + 33'(v_q)) > 33'(ONE));
    stat_o.t_rej     = !(t_q < best_q);
    stat_o.len_zero  = (sres_q[31:0] == '0);
    stat_o.div_done  = (dcnt_q == '0);
    stat_o.sqrt_done = (sbit_q == '0);
    stat_o.out_free  = !out_valid_o || !out_stall_i;
  end

  // control state with reset: ray, best distance, epsilon, output valid, unit counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        org_q[k] <= '0;
        dir_q[k] <= '0;
      end
      best_q      <= 32'sh7fffffff;
      eps_q       <= 31'd1;
      out_valid_o <= 1'b0;
      dcnt_q      <= '0;
      sbit_q      <= '0;
    end else begin
      if (cfg_we_i) eps_q <= cfg_wdata_i;
      if (cmd_i.take && !mode_i) begin
        org_q[0] <= a_x_i; org_q[1] <= a_y_i; org_q[2] <= a_z_i;
        dir_q[0] <= b_x_i; dir_q[1] <= b_y_i; dir_q[2] <= b_z_i;
        best_q   <= t_limit_i;
      end
      if (cmd_i.phase == rti_pkg::PH_OUT) begin
        out_valid_o <= 1'b1;
        if (cmd_i.out_hit) best_q <= t_q;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (cmd_i.phase == rti_pkg::PH_DIV_GO) dcnt_q <= CW'(DW);
      else if (dcnt_q != '0) dcnt_q <= dcnt_q - 1'b1;
      if (cmd_i.phase == rti_pkg::PH_SQRT_GO) sbit_q <= 64'h1 << 62;
      else sbit_q <= sbit_q >> 2;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && mode_i) begin
      va_q[0] <= a_x_i; va_q[1] <= a_y_i; va_q[2] <= a_z_i;
      vb_q[0] <= b_x_i; vb_q[1] <= b_y_i; vb_q[2] <= b_z_i;
      vc_q[0] <= c_x_i; vc_q[1] <= c_y_i; vc_q[2] <= c_z_i;
    end
    case (cmd_i.phase)
      rti_pkg::PH_EDGE: begin
        for (int k = 0; k < 3; k++) begin
          e1_q[k] <= rti_pkg::sat32(AW'(vb_q[k]) - AW'(va_q[k]));
          e2_q[k] <= rti_pkg::sat32(AW'(vc_q[k]) - AW'(va_q[k]));
          tv_q[k] <= rti_pkg::sat32(AW'(org_q[k]) - AW'(va_q[k]));
          pt_q[k] <= '0;
          nn_q[k] <= '0;
        end
      end
      rti_pkg::PH_MUL: prod_q <= 64'(opa) * 64'(opb);
      rti_pkg::PH_ACC: acc_q  <= acc_d;
      rti_pkg::PH_WB: begin
        case (cmd_i.op)
          rti_pkg::OP_P:   pv_q[comp] <= acc_sat;
          rti_pkg::OP_Q:   qv_q[comp] <= acc_sat;
          rti_pkg::OP_N:   nv_q[comp] <= acc_sat;
          rti_pkg::OP_DET: det_q <= acc_sat;
          rti_pkg::OP_SS:  ss_q  <= acc_q[63:0];
          rti_pkg::OP_PT:
            pt_q[cmd_i.term[1:0]] <= rti_pkg::sat32(AW'(org_q[cmd_i.term[1:0]]) + AW'(acc_sat));
          default:         num_q <= acc_sat;
        endcase
      end
      rti_pkg::PH_DIV_GO: begin
        dn_q   <= dstart;
        dq_q   <= '0;
        drem_q <= '0;
        dden_q <= dden_mag;
        // the root is an unsigned divisor
        dneg_q <= dnum[31] ^ (dden[31] && cmd_i.op != rti_pkg::OP_NRM);
      end
      rti_pkg::PH_DIV_WB: begin
        case (cmd_i.op)
          rti_pkg::OP_U: u_q <= dres;
          rti_pkg::OP_V: v_q <= dres;
          rti_pkg::OP_T: t_q <= dres;
          default:       nn_q[cmd_i.term[1:0]] <= dres[15:0];
        endcase
      end
      rti_pkg::PH_SQRT_GO: begin
        sx_q   <= ss_q;
        sres_q <= '0;
      end
      rti_pkg::PH_OUT: begin
        hit_o      <= cmd_i.out_hit;
        hit_t_o    <= cmd_i.out_hit ? t_q : best_q;
        point_x_o  <= cmd_i.out_hit ? pt_q[0] : '0;
        point_y_o  <= cmd_i.out_hit ? pt_q[1] : '0;
        point_z_o  <= cmd_i.out_hit ? pt_q[2] : '0;
        normal_x_o <= cmd_i.out_hit ? nn_q[0] : '0;
        normal_y_o <= cmd_i.out_hit ? nn_q[1] : '0;
        normal_z_o <= cmd_i.out_hit ? nn_q[2] : '0;
      end
      default: ;
    endcase
    // one quotient bit per cycle
    if (dcnt_q != '0) begin
      dn_q <= dn_q << 1;
      if (drem_t >= {1'b0, dden_q}) begin
        drem_q <= drem_t - {1'b0, dden_q};
        dq_q   <= {dq_q[DW-2:0], 1'b1};
      end else begin
        drem_q <= drem_t;
        dq_q   <= {dq_q[DW-2:0], 1'b0};
      end
    end
    // one root bit per cycle
    if (sbit_q != '0 && cmd_i.phase != rti_pkg::PH_SQRT_GO) begin
      if (sx_q >= s_try) begin
        sx_q   <= sx_q - s_try;
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Closest-hit ray / triangle tester, one ray held, triangles streamed past.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  input    | in_valid_i / in_stall_o | mode_i, a_*, b_*, c_*, t_limit_i
//  output   | out_valid_o/out_stall_i | hit_o, hit_t_o, point_*, normal_*
//  config   | cfg_we_i                | cfg_wdata_i (det_epsilon)
//
// A product term takes a multiply and an accumulate step on one shared
// 32x32 multiplier, plus a write-back step per component; a division
// yields 32+max(FRAC_BITS,14) quotient bits. After its result a triangle
// returns the block to idle before the next transfer is taken.
// Reset clears the ray, best distance (to the largest positive value) and
// sets det_epsilon to 1. A result waits in the output register while the
// next transfer is taken; a triangle stalls at its end until it is free.
`default_nettype none

module ray_triangle_intersect #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [30:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               mode_i,
  input  wire logic signed [31:0] a_x_i, a_y_i, a_z_i,
  input  wire logic signed [31:0] b_x_i, b_y_i, b_z_i,
  input  wire logic signed [31:0] c_x_i, c_y_i, c_z_i,
  input  wire logic signed [31:0] t_limit_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    hit_o,
  output logic signed [31:0]      hit_t_o,
  output logic signed [31:0]      point_x_o, point_y_o, point_z_o,
  output logic signed [15:0]      normal_x_o, normal_y_o, normal_z_o
);

  rti_pkg::cmd_t  cmd;
  rti_pkg::stat_t stat;

  rti_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .mode_i, .in_stall_o,
    .stat_i(stat), .cmd_o(cmd)
  );

  rti_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .cfg_we_i, .cfg_wdata_i,
    .mode_i, .a_x_i, .a_y_i, .a_z_i, .b_x_i, .b_y_i, .b_z_i,
    .c_x_i, .c_y_i, .c_z_i, .t_limit_i, .out_valid_o, .out_stall_i,
    .hit_o, .hit_t_o, .point_x_o, .point_y_o, .point_z_o,
    .normal_x_o, .normal_y_o, .normal_z_o
  );

endmodule

`default_nettype wire

### rtl/rti_checker.sv
// ----------------------------------------------------------------------------
// rti_checker
// Port-level checks for the intersect block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               mode_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic               hit_o,
  input wire logic signed [31:0] point_x_o,
  input wire logic signed [15:0] normal_x_o,
  input wire logic signed [15:0] normal_y_o,
  input wire logic signed [15:0] normal_z_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  // a triangle transfer makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i |=> in_stall_o)
    else $error("triangle accepted without going busy");

  // a miss reports zero point x and zero normal
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> point_x_o == 0 && normal_x_o == 0 &&
                              normal_y_o == 0 && normal_z_o == 0)
    else $error("miss with nonzero geometry");

  // unit normal x and z stay within one
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normal_x_o <= 16'sd16384 && normal_x_o >= -16'sd16384 &&
                    normal_z_o <= 16'sd16384 && normal_z_o >= -16'sd16384)
    else $error("normal out of range");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .out_valid_o,
  .out_stall_i, .hit_o, .point_x_o, .normal_x_o, .normal_y_o, .normal_z_o
);

`default_nettype wire
